// File: hw/rtl/dbrm_pkg.sv
// ----------------------------------------------------------------------------
// dbrm_pkg
// Shared types and constants for the decaying byte rate meter.
// ----------------------------------------------------------------------------
package dbrm_pkg;

   localparam int TIME_W      = 32;
   localparam int SIZE_W      = 16;
   localparam int LEVEL_W     = 40;   // Q32.8 level
   localparam int BYTES_W     = 48;
   localparam int RATE_W      = 32;
   localparam int LIMIT_W     = 16;
   localparam int MULB_W      = 10;   // dt below 1000, or the constant 1000
   localparam int DIVIDEND_W  = BYTES_W + MULB_W;   // 58
   localparam int DIVISOR_W   = 32;
   localparam int DIVCNT_W    = 6;

   // divide by 1000: base 2^16 long division, reciprocal multiply per digit
   localparam int DQ_CHUNK_W  = 16;
   localparam int DQ_REM_W    = 10;   // remainder below 1000
   localparam int DQ_V_W      = DQ_REM_W + DQ_CHUNK_W;
   localparam int DQ_X_W      = 64;
   localparam int DQ_CHUNKS   = DQ_X_W / DQ_CHUNK_W;
   localparam int DQ_CNT_W    = 2;
   localparam int RECIP_W     = 27;
   localparam int RECIP_SHIFT = 36;

   localparam int REQ_DATA_W  = 48;
   localparam int RSP_DATA_W  = 72;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET    = 16'd50;
   localparam logic [MULB_W-1:0]  MS_PER_SECOND  = 10'd1000;
   localparam logic [LEVEL_W-1:0] LEVEL_MAX      = {LEVEL_W{1'b1}};
   localparam logic [RECIP_W-1:0] RECIP_1000     = 27'd68719477;  // ceil(2^36/1000)

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECAY,
      S_DECAY_START,
      S_DECAY_QUO,
      S_DECAY_REM,
      S_ADD,
      S_AVG,
      S_AVG_START,
      S_AVG_WAIT,
      S_DONE
   } state_type;

   typedef struct packed {
      logic start;
      logic done;
   } div_ctl_type;

endpackage

// File: hw/rtl/dbrm_div.sv
// ----------------------------------------------------------------------------
// dbrm_div
// Restoring serial divider, one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module dbrm_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [dbrm_pkg::DIVIDEND_W-1:0]  dividend,
   input  logic [dbrm_pkg::DIVISOR_W-1:0]   divisor,
   output logic                             done,
   output logic [dbrm_pkg::DIVIDEND_W-1:0]  quotient
);
   import dbrm_pkg::*;

   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dvs_ff;
   logic [DIVCNT_W-1:0]   cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIVISOR_W:0]    shifted;
   logic [DIVISOR_W+1:0]  diff;

   always_comb begin
      shifted = {rem_ff, quo_ff[DIVIDEND_W-1]};
      diff    = {1'b0, shifted} - {2'b00, dvs_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = DIVCNT_W'(DIVIDEND_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[DIVISOR_W+1]) begin
            rem_in = diff[DIVISOR_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DIVISOR_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIVCNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (start) begin
         dvs_ff <= divisor;
      end
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: hw/rtl/decaying_byte_rate_meter_top.sv
// ----------------------------------------------------------------------------
// decaying_byte_rate_meter_top
// Leaky-bucket send rate meter with periodic bytes-per-second average.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one transaction per sent packet: its millisecond timestamp
//   and byte count. rsp_* returns exactly one transaction per request with the
//   send permission, the integer bucket level, the current average rate and a
//   flag marking a freshly closed averaging period.
//   csr_wr_en/csr_wr_data set the limit in kilobytes per second (0 = none).
// Sequencing:
//   One packet at a time under a small sequencer. The decay term level*dt is
//   divided by 1000 in four base-2^16 digits (reciprocal multiply, then
//   remainder per digit); the average uses a 58/32 serial divider (1 bit per
//   cycle). req_tready is high only while the sequencer is idle, so a new
//   packet is accepted only after the last one's result has been registered.
// Reset / stall:
//   Synchronous reset clears the level, times, byte counters and average and
//   restores the limit to 50. The response sits in an output register; a new
//   request can be taken while it waits, and if the receiver still stalls
//   when the next result is ready, the sequencer holds until rsp_tready.
// ----------------------------------------------------------------------------
module decaying_byte_rate_meter_top #(
   parameter int AVERAGE_PERIOD_MS = 500
) (
   input  logic                             clock,
   input  logic                             reset,
   // req_tdata: [31:0] time_ms (signed), [47:32] packet_bytes
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [dbrm_pkg::REQ_DATA_W-1:0]  req_tdata,
   // rsp_tdata: [0] can_send, [32:1] level_bytes, [64:33] average_rate,
   //            [65] average_updated, [71:66] zero
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [dbrm_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                             csr_wr_en,
   input  logic [dbrm_pkg::LIMIT_W-1:0]     csr_wr_data
);
   import dbrm_pkg::*;

   localparam logic [TIME_W-1:0] PERIOD = TIME_W'(AVERAGE_PERIOD_MS);

   state_type state_ff, state_in;

   // architectural state
   logic [LIMIT_W-1:0]    limit_ff;
   logic [LEVEL_W-1:0]    level_ff;
   logic [TIME_W-1:0]     level_time_ff;
   logic [BYTES_W-1:0]    total_ff;
   logic [BYTES_W-1:0]    psb_ff;        // bytes at period start
   logic [TIME_W-1:0]     pst_ff;        // time at period start
   logic [RATE_W-1:0]     avg_ff;

   // per-transaction work registers
   logic [TIME_W-1:0]     time_ff;
   logic [SIZE_W-1:0]     size_ff;
   logic [DIVIDEND_W-1:0] prod_ff;
   logic [DIVISOR_W-1:0]  elapsed_ff;
   logic                  upd_ff;

   // divide-by-1000 work registers, one digit per quotient/remainder pair
   logic [DQ_X_W-1:0]     dq_x_ff;       // dividend digits, next one on top
   logic [DQ_REM_W-1:0]   dq_rem_ff;
   logic [DQ_CHUNK_W-1:0] dq_q_ff;
   logic [LEVEL_W-1:0]    dq_quo_ff;
   logic [DQ_CNT_W-1:0]   dq_cnt_ff;

   // output register
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   // control
   logic                  req_fire;
   logic                  rsp_free;
   logic                  mul_avg;       // multiplier operand select
   div_ctl_type           div_ctl;
   logic [DIVIDEND_W-1:0] div_quo;

   // datapath terms
   logic [TIME_W:0]       dt;
   logic                  dt_pos;
   logic                  dt_big;
   logic [TIME_W:0]       elapsed;
   logic                  period_over;
   logic [BYTES_W-1:0]    delta;
   logic [BYTES_W-1:0]    mul_a;
   logic [MULB_W-1:0]     mul_b;
   logic [LEVEL_W:0]      level_sum;
   logic [LEVEL_W-1:0]    level_sat;
   logic [LEVEL_W-1:0]    level_dec;
   logic [RATE_W-1:0]     avg_sat;
   logic                  can_send;
   logic [DQ_V_W-1:0]     dq_v;
   logic [DQ_V_W+RECIP_W-1:0] dq_prod;
   logic [DQ_CHUNK_W-1:0] dq_q;
   logic [DQ_V_W-1:0]     dq_qx;
   logic [DQ_V_W-1:0]     dq_rem;
   logic [LEVEL_W-1:0]    dq_quo;

   assign req_fire = req_tvalid && req_tready;
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   // signed 33-bit time differences, no 32-bit wrap
   assign dt          = {time_ff[TIME_W-1], time_ff} - {level_time_ff[TIME_W-1], level_time_ff};
   assign dt_pos      = !dt[TIME_W] && (dt[TIME_W-1:0] != '0);
   assign dt_big      = !dt[TIME_W] && (dt[TIME_W-1:0] >= TIME_W'(MS_PER_SECOND));
   assign elapsed     = {time_ff[TIME_W-1], time_ff} - {pst_ff[TIME_W-1], pst_ff};
   assign period_over = !elapsed[TIME_W] && (elapsed[TIME_W-1:0] > PERIOD);
   assign delta       = total_ff - psb_ff;

   // shared multiplier: level*dt for decay, delta*1000 for the average
   assign mul_a = mul_avg ? delta : {{(BYTES_W-LEVEL_W){1'b0}}, level_ff};
   assign mul_b = mul_avg ? MS_PER_SECOND : dt[MULB_W-1:0];

   // one digit of the divide by 1000: remainder:digit is below 1000*2^16,
   // and the reciprocal multiply is exact over that range
   assign dq_v    = {dq_rem_ff, dq_x_ff[DQ_X_W-1 -: DQ_CHUNK_W]};
   assign dq_prod = {{RECIP_W{1'b0}}, dq_v} * {{DQ_V_W{1'b0}}, RECIP_1000};
   assign dq_q    = dq_prod[RECIP_SHIFT +: DQ_CHUNK_W];
   assign dq_qx   = {{(DQ_V_W-DQ_CHUNK_W){1'b0}}, dq_q_ff} *
                    {{(DQ_V_W-MULB_W){1'b0}}, MS_PER_SECOND};
   assign dq_rem  = dq_v - dq_qx;
   assign dq_quo  = {dq_quo_ff[LEVEL_W-DQ_CHUNK_W-1:0], dq_q_ff};

   assign level_sum = {1'b0, level_ff} + {{(LEVEL_W+1-SIZE_W-8){1'b0}}, size_ff, 8'h00};
   assign level_sat = level_sum[LEVEL_W] ? LEVEL_MAX : level_sum[LEVEL_W-1:0];
   assign level_dec = (dq_quo >= level_ff) ? '0 : level_ff - dq_quo;
   assign avg_sat   = (div_quo[DIVIDEND_W-1:RATE_W] != '0)
                    ? {RATE_W{1'b1}} : div_quo[RATE_W-1:0];

   // limit*1024 bytes in Q.8 is limit << 18
   assign can_send = (limit_ff == '0) ||
                     (level_ff <= {{(LEVEL_W-LIMIT_W-18){1'b0}}, limit_ff, 18'h0});

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) state_in = S_DECAY;
         end
         S_DECAY: begin
            if (dt_pos && !dt_big && (level_ff != '0)) state_in = S_DECAY_START;
            else                                       state_in = S_ADD;
         end
         S_DECAY_START: state_in = S_DECAY_QUO;
         S_DECAY_QUO:   state_in = S_DECAY_REM;
         S_DECAY_REM: begin
            if (dq_cnt_ff == '0) state_in = S_ADD;
            else                 state_in = S_DECAY_QUO;
         end
         S_ADD: state_in = S_AVG;
         S_AVG: begin
            if (period_over) state_in = S_AVG_START;
            else             state_in = S_DONE;
         end
         S_AVG_START: state_in = S_AVG_WAIT;
         S_AVG_WAIT: begin
            if (div_ctl.done) state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_tready    = 1'b0;
      mul_avg       = 1'b0;
      div_ctl.start = 1'b0;
      unique case (state_ff)
         S_IDLE:        req_tready = 1'b1;
         S_AVG:         mul_avg = 1'b1;
         S_AVG_START:   div_ctl.start = 1'b1;
         default: ;
      endcase
   end

   dbrm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_ctl.start),
      .dividend (prod_ff),
      .divisor  (elapsed_ff),
      .done     (div_ctl.done),
      .quotient (div_quo)
   );

   // payload / work registers
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_fire) begin
         time_ff <= req_tdata[TIME_W-1:0];
         size_ff <= req_tdata[TIME_W+SIZE_W-1:TIME_W];
      end
      if (state_ff == S_DECAY || state_ff == S_AVG) begin
         prod_ff <= DIVIDEND_W'(mul_a) * DIVIDEND_W'(mul_b);
      end
      if (state_ff == S_DECAY_START) begin
         dq_x_ff   <= {{(DQ_X_W-DIVIDEND_W){1'b0}}, prod_ff};
         dq_rem_ff <= '0;
         dq_quo_ff <= '0;
         dq_cnt_ff <= DQ_CNT_W'(DQ_CHUNKS-1);
      end
      if (state_ff == S_DECAY_QUO) begin
         dq_q_ff <= dq_q;
      end
      if (state_ff == S_DECAY_REM) begin
         dq_rem_ff <= dq_rem[DQ_REM_W-1:0];
         dq_x_ff   <= {dq_x_ff[DQ_X_W-DQ_CHUNK_W-1:0], {DQ_CHUNK_W{1'b0}}};
         dq_quo_ff <= dq_quo;
         dq_cnt_ff <= dq_cnt_ff - DQ_CNT_W'(1);
      end
      if (state_ff == S_AVG) begin
         elapsed_ff <= elapsed[TIME_W-1:0];
      end
      if (state_ff == S_DONE && rsp_free) begin
         rsp_data_ff <= {6'h00, upd_ff, avg_ff, level_ff[LEVEL_W-1:8], can_send};
      end
   end

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         limit_ff      <= LIMIT_RESET;
         level_ff      <= '0;
         level_time_ff <= '0;
         total_ff      <= '0;
         psb_ff        <= '0;
         pst_ff        <= '0;
         avg_ff        <= '0;
         upd_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) limit_ff <= csr_wr_data;
         // a new result replaces one that leaves at this edge
         if (state_ff == S_DONE && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  total_ff <= total_ff +
                     {{(BYTES_W-SIZE_W){1'b0}}, req_tdata[TIME_W+SIZE_W-1:TIME_W]};
               end
            end
            S_DECAY: begin
               level_time_ff <= time_ff;
               if (dt_big) level_ff <= '0;
            end
            S_DECAY_REM: begin
               if (dq_cnt_ff == '0) level_ff <= level_dec;
            end
            S_ADD: level_ff <= level_sat;
            S_AVG: begin
               upd_ff <= 1'b0;
               if (period_over) begin
                  psb_ff <= total_ff;
                  pst_ff <= time_ff;
               end
            end
            S_AVG_WAIT: begin
               if (div_ctl.done) begin
                  avg_ff <= avg_sat;
                  upd_ff <= 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: dv/dbrm_rate_checker.sv
// ----------------------------------------------------------------------------
// dbrm_rate_checker
// Watches the request, response and csr ports of the rate meter. Keeps its
// own copy of the bucket level, byte counters and average, predicts one
// reading per accepted request and compares it field by field with the
// response stream in order.
// ----------------------------------------------------------------------------
module dbrm_rate_checker #(
   parameter int AVERAGE_PERIOD_MS = 500
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [dbrm_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [dbrm_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                             csr_wr_en,
   input  logic [dbrm_pkg::LIMIT_W-1:0]     csr_wr_data,
   output int                               error_count,
   output int                               pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   import dbrm_pkg::*;

   typedef struct packed {
      logic                average_updated;
      logic [RATE_W-1:0]   average_rate;
      logic [31:0]         level_bytes;
      logic                can_send;
   } meter_reading_type;

   // mirrored meter state
   logic [LIMIT_W-1:0]  rate_limit_kb;
   logic [LEVEL_W-1:0]  bucket_q8;
   int                  bucket_ms;
   logic [BYTES_W-1:0]  byte_total;
   logic [BYTES_W-1:0]  period_bytes;
   int                  period_ms;
   logic [RATE_W-1:0]   avg_rate;

   meter_reading_type   pending_readings[$];

   function automatic meter_reading_type advance_meter(logic [31:0] stamp,
                                                       logic [SIZE_W-1:0] nbytes);
      longint          now_ms;
      longint          dt;
      longint          span;
      logic [63:0]     dec;
      logic [63:0]     sum;
      logic [63:0]     avg;
      logic [BYTES_W-1:0] delta;
      meter_reading_type r;

      now_ms     = longint'($signed(stamp));
      byte_total = byte_total + nbytes;

      // linear leak, only when time moved forward
      dt = now_ms - longint'(bucket_ms);
      if (dt >= 1000) begin
         bucket_q8 = '0;
      end else if (dt > 0) begin
         dec = (64'(bucket_q8) * 64'(dt)) / 64'd1000;
         bucket_q8 = (dec >= 64'(bucket_q8)) ? '0 : bucket_q8 - dec[LEVEL_W-1:0];
      end
      bucket_ms = $signed(stamp);

      sum = 64'(bucket_q8) + (64'(nbytes) << 8);
      bucket_q8 = (sum > 64'(LEVEL_MAX)) ? LEVEL_MAX : sum[LEVEL_W-1:0];

      r.average_updated = 1'b0;
      span = now_ms - longint'(period_ms);
      if (span > AVERAGE_PERIOD_MS) begin
         delta = byte_total - period_bytes;
         avg = (64'(delta) * 64'd1000) / 64'(span);
         avg_rate = (avg > 64'hFFFF_FFFF) ? '1 : avg[RATE_W-1:0];
         period_bytes = byte_total;
         period_ms = $signed(stamp);
         r.average_updated = 1'b1;
      end

      r.can_send     = (rate_limit_kb == '0) ||
                       (64'(bucket_q8) <= (64'(rate_limit_kb) << 18));
      r.level_bytes  = bucket_q8[LEVEL_W-1:8];
      r.average_rate = avg_rate;
      return r;
   endfunction

   function automatic void compare_field(string name, logic [63:0] want,
                                         logic [63:0] got);
      if (got !== want) begin
         $display("%0t rsp %s mismatch: expected %0h actual %0h",
                  $time, name, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      meter_reading_type want;
      if (reset) begin
         rate_limit_kb = LIMIT_RESET;
         bucket_q8     = '0;
         bucket_ms     = 0;
         byte_total    = '0;
         period_bytes  = '0;
         period_ms     = 0;
         avg_rate      = '0;
         error_count   = 0;
         pending_readings.delete();
      end else begin
         if (csr_wr_en)
            rate_limit_kb = csr_wr_data;
         // response first: it always belongs to an earlier request
         if (rsp_tvalid && rsp_tready) begin
            if (pending_readings.size() == 0) begin
               $display("%0t rsp transaction with nothing expected: actual %0h",
                        $time, rsp_tdata);
               error_count++;
            end else begin
               want = pending_readings.pop_front();
               compare_field("can_send", 64'(want.can_send), 64'(rsp_tdata[0]));
               compare_field("level_bytes", 64'(want.level_bytes),
                             64'(rsp_tdata[32:1]));
               compare_field("average_rate", 64'(want.average_rate),
                             64'(rsp_tdata[64:33]));
               compare_field("average_updated", 64'(want.average_updated),
                             64'(rsp_tdata[65]));
               compare_field("padding", 64'd0, 64'(rsp_tdata[71:66]));
            end
         end
         if (req_tvalid && req_tready)
            pending_readings.push_back(advance_meter(req_tdata[31:0],
                                                     req_tdata[47:32]));
      end
      pending_count = pending_readings.size();
   end

endmodule

// File: dv/tb_decaying_byte_rate_meter_top.sv
// ----------------------------------------------------------------------------
// tb_decaying_byte_rate_meter_top
// Drives packet transactions into the rate meter: a directed pass over the
// decay, averaging and limit corner cases, a back-to-back burst of full
// packets, then random traffic under several limits with random gaps and
// response stalls. The checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_decaying_byte_rate_meter_top;
   timeunit 1ns;
   timeprecision 1ps;

   import dbrm_pkg::*;

   localparam int PERIOD_MS       = 500;
   localparam int WATCHDOG_CYCLES = 4000;
   localparam int RANDOM_PHASES   = 4;
   localparam int PHASE_PACKETS   = 135;
   localparam int BURST_COUNT     = 40;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b1;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_wr_en = 1'b0;
   logic [LIMIT_W-1:0]     csr_wr_data = '0;

   int                     error_count;
   int                     pending_count;

   // random idling on both sides; cleared for the tail of the run
   logic                   idle_on = 1'b1;
   int                     stall_left = 0;
   int                     quiet_cycles = 0;
   logic [31:0]            clock_ms = '0;  // running packet timestamp

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   decaying_byte_rate_meter_top #(
      .AVERAGE_PERIOD_MS (PERIOD_MS)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   dbrm_rate_checker #(
      .AVERAGE_PERIOD_MS (PERIOD_MS)
   ) checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   // Receiver: random stall bursts while idling is on.
   always @(posedge clock) begin
      if (reset || !idle_on) begin
         rsp_tready <= 1'b1;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= (stall_left == 1);
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(1, 15);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Watchdog: ends the run when no transaction moves for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
         $display("tb_decaying_byte_rate_meter_top: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // One packet transaction; returns at the edge where it is accepted.
   task automatic send_packet(input logic [31:0] stamp, input logic [SIZE_W-1:0] nbytes);
      req_tvalid <= 1'b1;
      req_tdata  <= {nbytes, stamp};
      do @(posedge clock); while (!req_tready);
      clock_ms = stamp;
   endtask

   // Optional sender gap after a transaction.
   task automatic sender_gap();
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   endtask

   // Hold off the sender until every predicted reading has come back.
   // The first edge lets the checker see the last accepted request.
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   // Limit write; the meter is idle here, every request has its response.
   task automatic set_rate_limit(input logic [LIMIT_W-1:0] kbytes);
      wait_for_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= kbytes;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Random packet: mostly forward steps inside the leak window, some big
   // jumps, repeats, backward steps and fully random stamps.
   task automatic send_random_packet();
      logic [31:0]       stamp;
      logic [SIZE_W-1:0] nbytes;
      case ($urandom_range(0, 19))
         0:       stamp = $urandom;
         1:       stamp = clock_ms - $urandom_range(1, 2000);
         2, 3:    stamp = clock_ms + $urandom_range(1000, 5000);
         4, 5, 6: stamp = clock_ms;
         default: stamp = clock_ms + $urandom_range(1, 600);
      endcase
      case ($urandom_range(0, 7))
         0:       nbytes = '0;
         1:       nbytes = '1;
         2:       nbytes = SIZE_W'($urandom_range(0, 255));
         default: nbytes = SIZE_W'($urandom_range(0, 65535));
      endcase
      send_packet(stamp, nbytes);
      sender_gap();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed: reset limit of 50 kB/s ---
      send_packet(32'd0,    16'd0);      // no time step, no period close
      sender_gap();
      send_packet(32'd100,  16'hFFFF);   // max size
      send_packet(32'd100,  16'hFFFF);   // same stamp, no leak
      sender_gap();
      send_packet(32'd600,  16'd1000);   // half leak, period closes
      send_packet(32'd599,  16'd10);     // time backward
      sender_gap();
      send_packet(32'd1100, 16'd0);      // elapsed exactly the period: stays open
      send_packet(32'd1101, 16'd1);      // one past the period: closes
      send_packet(32'd2101, 16'd0);      // full second: level clamps to zero
      send_packet(32'd3099, 16'hFFFF);
      sender_gap();
      send_packet(32'd4098, 16'hAAAA);   // 999 ms leak, largest partial step
      send_packet(32'h7FFF_FFFF, 16'h5555);  // most positive stamp
      send_packet(32'h8000_0000, 16'd1);     // most negative: huge step back
      send_packet(32'hFFFF_FFFF, 16'hFFFF);
      send_packet(32'h0000_0000, 16'd2);

      // limit boundary: exactly limit*1024 bytes still allowed
      set_rate_limit(16'd1);
      send_packet(32'd10000, 16'd1024);
      send_packet(32'd10000, 16'd0);
      send_packet(32'd10000, 16'd1);     // one byte over
      set_rate_limit(16'd0);             // limit off
      send_packet(32'd10000, 16'hFFFF);

      // --- back-to-back burst of full packets at one stamp, then a close ---
      set_rate_limit(16'hFFFF);
      idle_on <= 1'b0;
      for (int i = 0; i < BURST_COUNT; i++)
         send_packet(32'd20000, 16'hFFFF);
      send_packet(32'd20501, 16'd0);
      idle_on <= 1'b1;

      // --- random traffic; last phase runs without idling ---
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0:       set_rate_limit(LIMIT_W'($urandom_range(30, 150)));
            1:       set_rate_limit(LIMIT_W'($urandom_range(0, 65535)));
            2:       set_rate_limit(LIMIT_W'($urandom_range(60, 120)));
            default: set_rate_limit(LIMIT_W'($urandom_range(1, 300)));
         endcase
         if (phase == RANDOM_PHASES - 1)
            idle_on <= 1'b0;
         for (int i = 0; i < PHASE_PACKETS; i++)
            send_random_packet();
      end

      wait_for_results();
      repeat (150) @(posedge clock);
      if (error_count == 0 && pending_count == 0)
         $display("tb_decaying_byte_rate_meter_top: PASS");
      else
         $display("tb_decaying_byte_rate_meter_top: FAIL");
      $finish;
   end

endmodule

// File: decaying_byte_rate_meter_top.f
hw/rtl/dbrm_pkg.sv
hw/rtl/dbrm_div.sv
hw/rtl/decaying_byte_rate_meter_top.sv
dv/dbrm_rate_checker.sv
dv/tb_decaying_byte_rate_meter_top.sv
